FILE: rtl/rld_pkg.sv
// Shared types and constants for the byte run-length decoder.
package rld_pkg;

  // Width of the stream position and value counters (they wrap at this width).
  localparam int unsigned COUNT_BITS = 32;
  // Width of each configuration register and of the consumed-byte field.
  localparam int unsigned CFG_W      = 32;
  // Compare width that holds both a counter and a register without loss.
  localparam int unsigned CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  // A repeat control byte c gives a run of c + RUN_BASE.
  localparam int unsigned RUN_BASE   = 3;

  // Decoder phase.
  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_STOPPED = 2'd3
  } phase_e;

  // Status reported on a result word.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_COUNT = 3'd1,
    ST_TOO_SMALL = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_MALFORMED = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_EXPECTED_COUNT  = 2'd0,
    REG_OUTPUT_CAPACITY = 2'd1,
    REG_STREAM_LENGTH   = 2'd2
  } cfg_idx_e;

  // Configuration register set.
  typedef struct packed {
    logic [CFG_W-1:0] expected_count;
    logic [CFG_W-1:0] output_capacity;
    logic [CFG_W-1:0] stream_length;
  } rld_cfg_t;

  // One result word.
  typedef struct packed {
    logic signed [7:0] value;
    logic [7:0]        run_count;
    logic              final_res;
    status_e           status_code;
    logic [CFG_W-1:0]  bytes_consumed;
  } rld_result_t;

endpackage

FILE: rtl/rld_cfg_regs.sv
// Configuration registers of the byte run-length decoder.
module rld_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output rld_pkg::rld_cfg_t   cfg_o
);
  import rld_pkg::*;

  rld_cfg_t cfg_q;

  // Register writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_count  <= CFG_W'(1);
      cfg_q.output_capacity <= '1;
      cfg_q.stream_length   <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EXPECTED_COUNT:  cfg_q.expected_count  <= cfg_data_i;
        REG_OUTPUT_CAPACITY: cfg_q.output_capacity <= cfg_data_i;
        REG_STREAM_LENGTH:   cfg_q.stream_length   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rld_in_reg.sv
// Input register stage: holds one stream byte until the decoder takes it.
module rld_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       pop_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);
  import rld_pkg::*;

  logic       held_valid_q;
  logic [7:0] held_byte_q;
  logic       accept;

  // Room when empty or when the held byte leaves this cycle
  assign in_ready_o = !held_valid_q || pop_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
    end else if (accept) begin
      held_valid_q <= 1'b1;
    end else if (pop_i) begin
      held_valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_byte_q <= data_byte_i;
    end
  end

  assign held_valid_o = held_valid_q;
  assign held_byte_o  = held_byte_q;

endmodule

FILE: rtl/rld_core.sv
// Decoder core: phase machine, stream counters and per-byte checks.
module rld_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rld_pkg::rld_cfg_t     cfg_i,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output rld_pkg::rld_result_t  res_o
);
  import rld_pkg::*;

  phase_e                phase_q, phase_d;
  logic [6:0]            lit_left_q, lit_left_d;
  logic [7:0]            pend_run_q, pend_run_d;
  logic [COUNT_BITS-1:0] bytes_seen_q, bytes_seen_d;
  logic [COUNT_BITS-1:0] values_out_q, values_out_d;

  logic [COUNT_BITS-1:0] bs_inc;
  logic [COUNT_BITS-1:0] vo_sum;
  logic [7:0]            run_len;
  logic [7:0]            rep_len;
  logic [7:0]            lit_len;
  logic [CMP_W-1:0]      ec_x, cap_x, sl_x, bs_x, bs_inc_x, vo_x, vo_sum_x;
  logic [CMP_W-1:0]      remaining, room;
  logic                  done;

  // Shared arithmetic
  assign bs_inc   = bytes_seen_q + COUNT_BITS'(1);
  assign run_len  = (phase_q == PH_REPEAT) ? pend_run_q : 8'd1;
  assign vo_sum   = values_out_q + COUNT_BITS'(run_len);
  assign rep_len  = {1'b0, byte_i[6:0]} + 8'(RUN_BASE);
  assign lit_len  = (~byte_i) + 8'd1;

  assign ec_x     = CMP_W'(cfg_i.expected_count);
  assign cap_x    = CMP_W'(cfg_i.output_capacity);
  assign sl_x     = CMP_W'(cfg_i.stream_length);
  assign bs_x     = CMP_W'(bytes_seen_q);
  assign bs_inc_x = CMP_W'(bs_inc);
  assign vo_x     = CMP_W'(values_out_q);
  assign vo_sum_x = CMP_W'(vo_sum);

  assign remaining = (ec_x > vo_x) ? (ec_x - vo_x) : '0;
  assign room      = sl_x - bs_inc_x;
  assign done      = (vo_sum_x >= ec_x);

  // Next state and result
  always_comb begin
    phase_d      = phase_q;
    lit_left_d   = lit_left_q;
    pend_run_d   = pend_run_q;
    bytes_seen_d = bytes_seen_q;
    values_out_d = values_out_q;
    res_valid_o  = 1'b0;
    res_o.value          = '0;
    res_o.run_count      = '0;
    res_o.final_res      = 1'b1;
    res_o.status_code    = ST_OK;
    res_o.bytes_consumed = '0;

    case (phase_q)
      PH_CONTROL: begin
        if (ec_x == '0) begin
          res_valid_o       = 1'b1;
          res_o.status_code = ST_BAD_COUNT;
        end else if (ec_x > cap_x) begin
          res_valid_o       = 1'b1;
          res_o.status_code = ST_TOO_SMALL;
        end else if (bs_x >= sl_x) begin
          res_valid_o       = 1'b1;
          res_o.status_code = ST_TRUNCATED;
        end else begin
          bytes_seen_d = bs_inc;
          if (!byte_i[7]) begin
            // repeat run: value byte must still be inside the stream
            if (bs_inc_x >= sl_x) begin
              res_valid_o       = 1'b1;
              res_o.status_code = ST_TRUNCATED;
            end else if (CMP_W'(rep_len) > remaining) begin
              res_valid_o       = 1'b1;
              res_o.status_code = ST_MALFORMED;
            end else begin
              pend_run_d = rep_len;
              phase_d    = PH_REPEAT;
            end
          end else begin
            // literal group: all its bytes must fit in the stream
            if ((bs_inc_x > sl_x) || (CMP_W'(lit_len) > room)) begin
              res_valid_o       = 1'b1;
              res_o.status_code = ST_TRUNCATED;
            end else if (CMP_W'(lit_len) > remaining) begin
              res_valid_o       = 1'b1;
              res_o.status_code = ST_MALFORMED;
            end else begin
              lit_left_d = 7'(lit_len - 8'd1);
              phase_d    = PH_LITERAL;
            end
          end
        end
        if (res_valid_o) begin
          phase_d = PH_STOPPED;
        end
      end

      PH_REPEAT, PH_LITERAL: begin
        if (phase_q == PH_REPEAT) begin
          phase_d = PH_CONTROL;
        end else if (lit_left_q == '0) begin
          phase_d = PH_CONTROL;
        end else begin
          lit_left_d = lit_left_q - 7'd1;
        end
        bytes_seen_d    = bs_inc;
        values_out_d    = vo_sum;
        res_valid_o     = 1'b1;
        res_o.value     = signed'(byte_i);
        res_o.run_count = run_len;
        res_o.final_res = done;
        if (done) begin
          phase_d              = PH_STOPPED;
          res_o.status_code    = (bs_inc_x == sl_x) ? ST_OK : ST_MALFORMED;
          res_o.bytes_consumed = CFG_W'(bs_inc);
        end
      end

      PH_STOPPED: ;

      default: ;
    endcase

    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_CONTROL;
      lit_left_q   <= '0;
      pend_run_q   <= '0;
      bytes_seen_q <= '0;
      values_out_q <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      lit_left_q   <= lit_left_d;
      pend_run_q   <= pend_run_d;
      bytes_seen_q <= bytes_seen_d;
      values_out_q <= values_out_d;
    end
  end

endmodule

FILE: rtl/rld_out_reg.sv
// Result register: holds one result word until the receiver takes it.
module rld_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  res_valid_i,
  input  rld_pkg::rld_result_t  res_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output rld_pkg::rld_result_t  res_o
);
  import rld_pkg::*;

  logic        out_valid_q;
  rld_result_t res_q;

  // load_i only comes when the register is free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/byte_run_length_decoder_top.sv
// Top level of the byte run-length decoder.
//
// Encoded bytes enter on the input channel (data_byte_i, valid/ready). Each
// value byte gives one result word on the output channel: the value, its run
// count, and on the last word the final flag, status and bytes consumed.
// Control bytes give no word unless they fail a check, which gives a final
// status-only word. After a final word the block swallows input until reset.
// Configuration registers are written through cfg_valid_i/cfg_index_i/
// cfg_data_i, always ready; write them only while the block is idle.
// Path: a byte is registered in the input register on acceptance and is decoded
// into the result register once that register is free or draining.
// Throughput: one byte per cycle unless the receiver stalls, set by the single
// decode step between the input and result registers. On a stall, the
// result register holds a word and the input register a byte; then in_ready_o
// drops. Reset clears both valid flags, the counters and the phase, and loads
// the register defaults (expected count 1, capacity all ones, stream length 1).
module byte_run_length_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] value_o,
  output logic [7:0]        run_count_o,
  output logic              final_res_o,
  output logic [2:0]        status_code_o,
  output logic [31:0]       bytes_consumed_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import rld_pkg::*;

  rld_cfg_t    cfg;
  rld_result_t core_res;
  rld_result_t out_res;
  logic        held_valid;
  logic [7:0]  held_byte;
  logic        core_valid;
  logic        step;

  assign cfg_ready_o = 1'b1;

  // Decode when a byte is held and the result register can take a word
  assign step = held_valid && (!out_valid_o || out_ready_i);

  rld_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rld_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .pop_i        (step),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  rld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .byte_i      (held_byte),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  rld_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (core_valid),
    .res_i       (core_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  // Result fields
  assign value_o          = out_res.value;
  assign run_count_o      = out_res.run_count;
  assign final_res_o      = out_res.final_res;
  assign status_code_o    = out_res.status_code;
  assign bytes_consumed_o = out_res.bytes_consumed;

endmodule

FILE: verif/rld_scoreboard_pkg.sv
// Decode predictor and result-word scoreboard for the byte run-length decoder testbench.
`timescale 1ns / 100ps
package rld_scoreboard_pkg;
  import rld_pkg::*;

  class rld_scoreboard;
    // Shadow of the configuration registers
    rld_cfg_t    regs;
    // Shadow of the decoder state
    phase_e      phase;
    logic [6:0]  lits_left;
    logic [7:0]  run_len;
    logic [31:0] bytes_seen;
    logic [31:0] values_out;
    // Result words still due from the block, oldest first
    rld_result_t due_words[$];
    int unsigned n_bytes;
    int unsigned n_words;
    int unsigned n_errors;

    function new();
      regs.expected_count  = 32'd1;
      regs.output_capacity = '1;
      regs.stream_length   = 32'd1;
      phase      = PH_CONTROL;
      lits_left  = '0;
      run_len    = '0;
      bytes_seen = '0;
      values_out = '0;
      n_bytes    = 0;
      n_words    = 0;
      n_errors   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        REG_EXPECTED_COUNT:  regs.expected_count  = data;
        REG_OUTPUT_CAPACITY: regs.output_capacity = data;
        REG_STREAM_LENGTH:   regs.stream_length   = data;
        default: ;
      endcase
    endfunction

    function void push_word(logic [7:0] val, logic [7:0] run, logic fin, status_e st,
                            logic [31:0] used);
      rld_result_t w;
      w.value          = val;
      w.run_count      = run;
      w.final_res      = fin;
      w.status_code    = st;
      w.bytes_consumed = used;
      due_words.push_back(w);
    endfunction

    // Failed check: status-only final word, then nothing until reset
    function void stop_with(status_e st);
      phase = PH_STOPPED;
      push_word(8'd0, 8'd0, 1'b1, st, 32'd0);
    endfunction

    // Value byte: one word; the last expected value closes the stream
    function void take_value(logic [7:0] b, logic [7:0] run);
      status_e st;
      bytes_seen = bytes_seen + 32'd1;
      values_out = values_out + {24'd0, run};
      if (values_out >= regs.expected_count) begin
        // trailing bytes left in the stream count as malformed
        st    = (bytes_seen == regs.stream_length) ? ST_OK : ST_MALFORMED;
        phase = PH_STOPPED;
        push_word(b, run, 1'b1, st, bytes_seen);
      end else begin
        push_word(b, run, 1'b0, ST_OK, 32'd0);
      end
    endfunction

    // Control byte: argument checks, then truncation, then overlong group
    function void take_control(logic [7:0] b);
      logic [31:0] remaining;
      logic [31:0] length;
      if (regs.expected_count == 32'd0) begin
        stop_with(ST_BAD_COUNT);
      end else if (regs.expected_count > regs.output_capacity) begin
        stop_with(ST_TOO_SMALL);
      end else if (bytes_seen >= regs.stream_length) begin
        stop_with(ST_TRUNCATED);
      end else begin
        bytes_seen = bytes_seen + 32'd1;
        // values already past the target leave no room at all
        remaining  = (regs.expected_count > values_out) ? regs.expected_count - values_out
                                                        : 32'd0;
        if (!b[7]) begin
          length = {24'd0, b} + RUN_BASE;
          if (bytes_seen >= regs.stream_length) begin
            stop_with(ST_TRUNCATED);
          end else if (length > remaining) begin
            stop_with(ST_MALFORMED);
          end else begin
            run_len = length[7:0];
            phase   = PH_REPEAT;
          end
        end else begin
          length = 32'd256 - {24'd0, b};
          if (bytes_seen > regs.stream_length ||
              length > regs.stream_length - bytes_seen) begin
            stop_with(ST_TRUNCATED);
          end else if (length > remaining) begin
            stop_with(ST_MALFORMED);
          end else begin
            lits_left = length[6:0] - 7'd1;
            phase     = PH_LITERAL;
          end
        end
      end
    endfunction

    // Note an accepted input word and queue what it should produce
    function void decode_byte(logic [7:0] b);
      n_bytes++;
      case (phase)
        PH_CONTROL: take_control(b);
        PH_REPEAT: begin
          phase = PH_CONTROL;
          take_value(b, run_len);
        end
        PH_LITERAL: begin
          if (lits_left == 7'd0) phase = PH_CONTROL;
          else lits_left = lits_left - 7'd1;
          take_value(b, 8'd1);
        end
        default: ;
      endcase
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        n_errors++;
      end
    endfunction

    // Compare an accepted result word with the oldest one due
    function void check_word(rld_result_t got);
      rld_result_t want;
      n_words++;
      if (due_words.size() == 0) begin
        $error("result word with nothing due: value 0x%0h run %0d status %0d",
               got.value, got.run_count, got.status_code);
        n_errors++;
      end else begin
        want = due_words.pop_front();
        check_field("value", {24'd0, want.value}, {24'd0, got.value});
        check_field("run_count", {24'd0, want.run_count}, {24'd0, got.run_count});
        check_field("final_res", {31'd0, want.final_res}, {31'd0, got.final_res});
        check_field("status_code", {29'd0, want.status_code}, {29'd0, got.status_code});
        check_field("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
      end
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction
  endclass

endpackage

FILE: verif/tb_byte_run_length_decoder_top.sv
// Testbench top for the byte run-length decoder: stimulus, handshakes and the end of run.
`timescale 1ns / 100ps
module tb_byte_run_length_decoder_top;
  import rld_pkg::*;
  import rld_scoreboard_pkg::*;

  localparam int unsigned N_ITEMS      = 700;
  localparam logic [31:0] ALL_ONES     = '1;
  localparam int unsigned LATENCY_WAIT = 4;
  localparam int unsigned DRAIN_LIMIT  = 4000;

  // How the single stream of the run is brought to its end
  typedef enum logic [3:0] {
    END_DONE,
    END_TRAILING,
    END_BAD_COUNT,
    END_TOO_SMALL,
    END_EXHAUSTED,
    END_REPEAT_CUT,
    END_LITERAL_CUT,
    END_OVERLONG,
    END_SPENT
  } stream_end_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        data_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic signed [7:0] value_o;
  logic [7:0]        run_count_o;
  logic              final_res_o;
  logic [2:0]        status_code_o;
  logic [31:0]       bytes_consumed_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [31:0]       cfg_data_i;

  rld_scoreboard sb;
  int unsigned   n_cfg;
  bit            in_gaps_on;
  bit            out_stalls_on;
  stream_end_e   ending;

  byte_run_length_decoder_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .run_count_o      (run_count_o),
    .final_res_o      (final_res_o),
    .status_code_o    (status_code_o),
    .bytes_consumed_o (bytes_consumed_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watch all three channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_word(rld_result_t'({value_o, run_count_o, final_res_o, status_code_o,
                                     bytes_consumed_o}));
      end
      if (in_valid_i && in_ready_o) sb.decode_byte(data_byte_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
    end
  end

  // Result side: random stall before each word, with stall-free stretches
  initial begin : result_side
    int unsigned stall;
    out_ready_i   = 1'b0;
    out_stalls_on = 1'b1;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) out_stalls_on = !out_stalls_on;
      stall = out_stalls_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // One encoded byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_gaps_on = !in_gaps_on;
    gap = in_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    n_cfg++;
  endtask

  // Stop sending and let every due word and any control byte in flight clear
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (LATENCY_WAIT) @(negedge clk_i);
  endtask

  function automatic logic [31:0] group_values(input logic [7:0] ctrl);
    return ctrl[7] ? 32'd256 - {24'd0, ctrl} : {24'd0, ctrl} + 32'd3;
  endfunction

  function automatic logic [31:0] group_bytes(input logic [7:0] ctrl);
    return ctrl[7] ? 32'd257 - {24'd0, ctrl} : 32'd2;
  endfunction

  // Mostly uniform, with the shortest and longest runs and groups favoured
  function automatic logic [7:0] pick_control();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'h7F;
        2:       return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Control byte followed by its value bytes, random content
  task automatic send_group(input logic [7:0] ctrl);
    send_byte(ctrl);
    if (ctrl[7]) repeat (group_values(ctrl)) send_byte(8'($urandom_range(0, 255)));
    else send_byte(8'($urandom_range(0, 255)));
  endtask

  // New register setting between groups that keeps the stream alive
  task automatic retune();
    logic [31:0] target;
    case ($urandom_range(0, 4))
      0: begin
        target = sb.values_out + 32'd1_000_000 + 32'($urandom_range(0, 1000));
        if (target > sb.regs.output_capacity)
          set_reg(REG_OUTPUT_CAPACITY, $urandom_range(0, 1) ? target : ALL_ONES);
        set_reg(REG_EXPECTED_COUNT, target);
      end
      1: begin
        set_reg(REG_OUTPUT_CAPACITY, ALL_ONES);
        set_reg(REG_EXPECTED_COUNT, ALL_ONES);
      end
      // capacity exactly equal to the count is still legal
      2: set_reg(REG_OUTPUT_CAPACITY, sb.regs.expected_count);
      3: set_reg(REG_STREAM_LENGTH,
                 sb.bytes_seen + 32'd1_000_000 + 32'($urandom_range(0, 1000)));
      default: set_reg(REG_STREAM_LENGTH, ALL_ONES);
    endcase
  endtask

  // Close the stream by one randomly chosen ending, then feed bytes that must be ignored
  task automatic close_stream();
    logic [7:0]  ctrl;
    logic [31:0] v;
    logic [31:0] b;
    logic [31:0] n;
    settle();
    v      = sb.values_out;
    b      = sb.bytes_seen;
    ending = stream_end_e'($urandom_range(0, 8));
    set_reg(REG_OUTPUT_CAPACITY, ALL_ONES);
    case (ending)
      END_DONE, END_TRAILING: begin
        ctrl = pick_control();
        set_reg(REG_EXPECTED_COUNT, v + group_values(ctrl));
        if ($urandom_range(0, 1)) set_reg(REG_OUTPUT_CAPACITY, v + group_values(ctrl));
        if (ending == END_DONE) set_reg(REG_STREAM_LENGTH, b + group_bytes(ctrl));
        else if ($urandom_range(0, 1)) set_reg(REG_STREAM_LENGTH, ALL_ONES);
        else set_reg(REG_STREAM_LENGTH,
                     b + group_bytes(ctrl) + 32'd1 + 32'($urandom_range(0, 100)));
        send_group(ctrl);
      end
      END_BAD_COUNT: begin
        set_reg(REG_EXPECTED_COUNT, 32'd0);
        send_byte(pick_control());
      end
      END_TOO_SMALL: begin
        set_reg(REG_EXPECTED_COUNT, v + 32'd1000);
        set_reg(REG_OUTPUT_CAPACITY, $urandom_range(0, 1) ? 32'd0 : v + 32'd999);
        send_byte(pick_control());
      end
      END_EXHAUSTED: begin
        set_reg(REG_STREAM_LENGTH, $urandom_range(0, 1) ? 32'd1 : b);
        send_byte(pick_control());
      end
      END_REPEAT_CUT: begin
        // repeat control as the very last byte of the stream
        set_reg(REG_STREAM_LENGTH, b + 32'd1);
        send_byte({1'b0, 7'($urandom_range(0, 127))});
      end
      END_LITERAL_CUT: begin
        ctrl = 8'($urandom_range(128, 254));
        n    = group_values(ctrl);
        set_reg(REG_STREAM_LENGTH, b + 32'd1 + 32'($urandom_range(0, n - 1)));
        send_byte(ctrl);
      end
      END_OVERLONG: begin
        ctrl = $urandom_range(0, 1) ? {1'b0, 7'($urandom_range(0, 127))}
                                    : 8'($urandom_range(128, 254));
        set_reg(REG_EXPECTED_COUNT, v + 32'($urandom_range(1, group_values(ctrl) - 1)));
        send_byte(ctrl);
      end
      default: begin
        // count lowered below what is already out: nothing left to decode
        set_reg(REG_EXPECTED_COUNT, 32'($urandom_range(1, v)));
        send_byte(pick_control());
      end
    endcase
    repeat (6) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned cycles;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'd0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_EXPECTED_COUNT;
    cfg_data_i    = 32'd0;
    in_gaps_on    = 1'b1;
    n_cfg         = 0;
    ending        = END_DONE;
    sb            = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Widest setting for the body of the stream
    set_reg(REG_EXPECTED_COUNT, ALL_ONES);
    set_reg(REG_OUTPUT_CAPACITY, ALL_ONES);
    set_reg(REG_STREAM_LENGTH, ALL_ONES);

    // Directed: shortest and longest runs, single and short literal groups
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFD);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'h01);

    // Random well-formed groups, starting with the longest literal group
    send_group(8'h80);
    while (sb.n_bytes < N_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        settle();
        retune();
      end
      send_group(pick_control());
    end

    close_stream();

    // Drain
    in_valid_i <= 1'b0;
    cycles = 0;
    while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk_i);
      cycles++;
    end
    repeat (2 * LATENCY_WAIT) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d result words never arrived", sb.pending());
      sb.n_errors++;
    end

    $display("Sent %0d encoded bytes, checked %0d result words, made %0d register writes",
             sb.n_bytes, sb.n_words, n_cfg);
    $display("Stream ended by case %s, followed by bytes the block must ignore",
             ending.name());
    if (sb.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: byte_run_length_decoder_top.f
rtl/rld_pkg.sv
rtl/rld_cfg_regs.sv
rtl/rld_in_reg.sv
rtl/rld_core.sv
rtl/rld_out_reg.sv
rtl/byte_run_length_decoder_top.sv
verif/rld_scoreboard_pkg.sv
verif/tb_byte_run_length_decoder_top.sv
